[rtl/fpw_pkg.sv]
// Shared types and constants for the four-level page walker.
// Depends on nothing; every rtl file imports it.
`default_nettype none

package fpw_pkg;

   // Physical address width and the derived field widths
   localparam int PHYS_ADDR_BITS = 52;
   localparam int ADDR_W         = 52;
   localparam int VA_W           = 48;
   localparam int ENTRY_W        = 64;
   localparam int PAGE_BITS      = 12;
   localparam int IDX_W          = 9;
   localparam int FRAME_W        = PHYS_ADDR_BITS - PAGE_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   // Input word codes
   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_REPLY     = 1'b1;

   // Walk levels: top table first, leaf table last
   localparam logic [1:0] LEVEL_TOP  = 2'd0;
   localparam logic [1:0] LEVEL_LEAF = 2'd3;

   // Result word kinds
   typedef enum logic {
      KIND_READ = 1'b0,
      KIND_DONE = 1'b1
   } kind_type;

   // Work handed from front to back
   typedef struct packed {
      kind_type           kind;
      logic [1:0]         level;
      logic [FRAME_W-1:0] frame;
      logic [VA_W-1:0]    vaddr;
   } cmd_type;

   // Result word
   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] address;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/fpw_front.sv]
// Front end: takes input words, tracks walk state and drops misfits.
// Depends on fpw_pkg; feeds fpw_cmd_queue.
`default_nettype none

module fpw_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [fpw_pkg::ADDR_W-1:0]    csr_table_base,
   input  wire logic                          accept,
   input  wire logic                          req_type,
   input  wire logic [fpw_pkg::VA_W-1:0]      req_virt_addr,
   input  wire logic [fpw_pkg::ENTRY_W-1:0]   req_read_data,
   output fpw_pkg::cmd_type                   cmd,
   output logic                               cmd_valid
);
   import fpw_pkg::*;

   logic [ADDR_W-1:0] table_base_ff, table_base_in;
   logic              busy_ff, busy_in;
   logic [1:0]        level_ff, level_in;
   logic [VA_W-1:0]   vaddr_ff, vaddr_in;

   // Classify the word and advance the walk
   always_comb begin
      table_base_in = csr_we ? csr_table_base : table_base_ff;
      busy_in       = busy_ff;
      level_in      = level_ff;
      vaddr_in      = vaddr_ff;
      cmd_valid     = 1'b0;
      cmd.kind      = KIND_READ;
      cmd.level     = LEVEL_TOP;
      cmd.frame     = table_base_ff[PHYS_ADDR_BITS-1:PAGE_BITS];
      cmd.vaddr     = vaddr_ff;
      if (accept) begin
         if (req_type == REQ_TRANSLATE) begin
            if (!busy_ff) begin
               busy_in   = 1'b1;
               level_in  = LEVEL_TOP;
               vaddr_in  = req_virt_addr;
               cmd_valid = 1'b1;
               cmd.vaddr = req_virt_addr;
            end
         end else if (busy_ff) begin
            cmd_valid = 1'b1;
            cmd.frame = req_read_data[PHYS_ADDR_BITS-1:PAGE_BITS];
            if (level_ff != LEVEL_LEAF) begin
               level_in  = level_ff + 2'd1;
               cmd.level = level_ff + 2'd1;
            end else begin
               busy_in  = 1'b0;
               level_in = LEVEL_TOP;
               cmd.kind = KIND_DONE;
            end
         end
      end
   end

   // Walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
         busy_ff       <= 1'b0;
         level_ff      <= LEVEL_TOP;
         vaddr_ff      <= '0;
      end else begin
         table_base_ff <= table_base_in;
         busy_ff       <= busy_in;
         level_ff      <= level_in;
         vaddr_ff      <= vaddr_in;
      end
   end

endmodule

`default_nettype wire

[rtl/fpw_cmd_queue.sv]
// Two-entry queue between front and back of the walker.
// Depends on fpw_pkg for the command word type.
`default_nettype none

module fpw_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire fpw_pkg::cmd_type cmd_in,
   output logic                  full,
   input  wire logic             pop,
   output fpw_pkg::cmd_type      cmd_out,
   output logic                  empty
);
   import fpw_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign cmd_out = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

[rtl/fpw_back.sv]
// Back end: forms entry or physical addresses and buffers result words.
// Depends on fpw_pkg; drains fpw_cmd_queue.
`default_nettype none

module fpw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fpw_pkg::cmd_type           cmd,
   input  wire logic                       cmd_empty,
   output logic                            cmd_pop,
   output logic                            empty,
   input  wire logic                       pop,
   output logic                            rsp_out_kind,
   output logic [fpw_pkg::ADDR_W-1:0]      rsp_address
);
   import fpw_pkg::*;

   rsp_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop, has_room;
   logic [IDX_W-1:0]  index;
   logic [PAGE_BITS-1:0] low_bits;
   rsp_type           result;

   // Pick the table index for this level
   always_comb begin
      case (cmd.level)
         2'd0:    index = cmd.vaddr[47:39];
         2'd1:    index = cmd.vaddr[38:30];
         2'd2:    index = cmd.vaddr[29:21];
         2'd3:    index = cmd.vaddr[20:12];
         default: index = cmd.vaddr[47:39];
      endcase
   end

   // Frame joined with entry offset or page offset
   always_comb begin
      low_bits       = (cmd.kind == KIND_DONE) ? cmd.vaddr[PAGE_BITS-1:0]
                                               : {index, 3'b000};
      result.kind    = cmd.kind;
      result.address = ADDR_W'({cmd.frame, low_bits});
   end

   // Output buffer control
   assign do_pop   = pop && !empty;
   assign empty    = (count_ff == '0);
   assign has_room = (count_ff != QCNT_W'(QUEUE_DEPTH)) || do_pop;
   assign cmd_pop  = has_room && !cmd_empty;

   always_comb begin
      wr_ptr_in = cmd_pop ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (cmd_pop && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_out_kind = slot_ff[rd_ptr_ff].kind;
   assign rsp_address  = slot_ff[rd_ptr_ff].address;

endmodule

`default_nettype wire

[rtl/four_level_page_walker.sv]
// Top level of the four-level page walker: front, command queue, back.
// Depends on fpw_pkg, fpw_front, fpw_cmd_queue and fpw_back.
`default_nettype none

// Walks a four-level page table. A translate word (req_type 0) yields a read
// request for the top-level entry; each reply word (req_type 1) yields the
// next entry read, and the fourth reply yields the physical address (frame
// bits of the last entry joined with the page offset). A translate word while
// a walk is open, and a reply while none is, are dropped with no result.
// Each word is registered in the command queue and then in the back's result
// buffer; one word is accepted each cycle unless full. Two-entry queues
// after the front and in the back absorb stalls on pop. The user must write
// csr_table_base only while no walk is open; the block does not enforce it.
module four_level_page_walker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [fpw_pkg::ADDR_W-1:0]  csr_table_base,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic                        req_type,
   input  wire logic [fpw_pkg::VA_W-1:0]    req_virt_addr,
   input  wire logic [fpw_pkg::ENTRY_W-1:0] req_read_data,
   output logic                             empty,
   input  wire logic                        pop,
   output logic                             rsp_out_kind,
   output logic [fpw_pkg::ADDR_W-1:0]       rsp_address
);
   import fpw_pkg::*;

   cmd_type front_cmd, back_cmd;
   logic    front_valid, accept, cmd_empty, cmd_pop;

   assign accept = push && !full;

   // Classify words and track the walk
   fpw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_table_base (csr_table_base),
      .accept         (accept),
      .req_type       (req_type),
      .req_virt_addr  (req_virt_addr),
      .req_read_data  (req_read_data),
      .cmd            (front_cmd),
      .cmd_valid      (front_valid)
   );

   // Decoupling queue
   fpw_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .cmd_in  (front_cmd),
      .full    (full),
      .pop     (cmd_pop),
      .cmd_out (back_cmd),
      .empty   (cmd_empty)
   );

   // Address assembly and result buffer
   fpw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd          (back_cmd),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_kind (rsp_out_kind),
      .rsp_address  (rsp_address)
   );

endmodule

`default_nettype wire

[tb/fpw_checker.sv]
// Result checker for the four-level page walker: predicts each result word from the
// accepted input words and compares it with what the block pops out.
// Depends on fpw_pkg for widths, word codes and the result word type.
`timescale 1ns / 1ps

module fpw_checker
   import fpw_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [ADDR_W-1:0]  csr_table_base,
   input  wire logic               push,
   input  wire logic               full,
   input  wire logic               req_type,
   input  wire logic [VA_W-1:0]    req_virt_addr,
   input  wire logic [ENTRY_W-1:0] req_read_data,
   input  wire logic               empty,
   input  wire logic               pop,
   input  wire logic               rsp_out_kind,
   input  wire logic [ADDR_W-1:0]  rsp_address,
   output int                      fail_count,
   output int                      pending,
   output logic                    walk_open
);

   // Shadow of the walker state and its one register
   logic [ADDR_W-1:0] table_base;
   logic [1:0]        walk_level;
   logic [VA_W-1:0]   saved_vaddr;
   rsp_type           expected_words[$];

   // 9-bit table index of a level: top table uses VA[47:39], leaf VA[20:12]
   function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0] level);
      return IDX_W'(va >> (PAGE_BITS + IDX_W * (3 - int'(level))));
   endfunction

   // Frame bits PHYS_ADDR_BITS-1:12 of an entry, low 12 bits cleared
   function automatic logic [ADDR_W-1:0] frame_of(input logic [ENTRY_W-1:0] entry);
      return ADDR_W'(entry[PHYS_ADDR_BITS-1:PAGE_BITS]) << PAGE_BITS;
   endfunction

   // Entry address inside a table; wraps at the address width
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] frame,
                                                    input logic [VA_W-1:0] va,
                                                    input logic [1:0] level);
      return frame + ADDR_W'({table_index(va, level), 3'b000});
   endfunction

   // Advance the walk by one accepted input word, queueing the word it yields
   task automatic walk_step(input logic kind_in, input logic [VA_W-1:0] va,
                            input logic [ENTRY_W-1:0] data);
      rsp_type word;
      if (kind_in == REQ_TRANSLATE) begin
         // translate while a walk is open: dropped
         if (!walk_open) begin
            walk_open    = 1'b1;
            walk_level   = LEVEL_TOP;
            saved_vaddr  = va;
            word.kind    = KIND_READ;
            word.address = entry_addr(frame_of(ENTRY_W'(table_base)), va, LEVEL_TOP);
            expected_words.push_back(word);
         end
      end else if (walk_open) begin
         // reply with no walk open: dropped
         if (walk_level != LEVEL_LEAF) begin
            walk_level   = walk_level + 2'd1;
            word.kind    = KIND_READ;
            word.address = entry_addr(frame_of(data), saved_vaddr, walk_level);
         end else begin
            walk_open    = 1'b0;
            walk_level   = LEVEL_TOP;
            word.kind    = KIND_DONE;
            word.address = frame_of(data) | ADDR_W'(saved_vaddr[PAGE_BITS-1:0]);
         end
         expected_words.push_back(word);
      end
   endtask

   // Sample both channels and the register port at each rising edge
   always @(posedge clock) begin : check_edge
      rsp_type oldest;
      if (reset) begin
         table_base  = '0;
         walk_open   = 1'b0;
         walk_level  = LEVEL_TOP;
         saved_vaddr = '0;
         fail_count  = 0;
         expected_words.delete();
      end else begin
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: kind %0d, address %h",
                      rsp_out_kind, rsp_address);
               fail_count++;
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_out_kind !== oldest.kind) begin
                  $error("rsp_out_kind: expected %0d, actual %0d", oldest.kind, rsp_out_kind);
                  fail_count++;
               end
               if (rsp_address !== oldest.address) begin
                  $error("rsp_address: expected %h, actual %h", oldest.address, rsp_address);
                  fail_count++;
               end
            end
         end
         if (push && !full)
            walk_step(req_type, req_virt_addr, req_read_data);
         if (csr_we)
            table_base = csr_table_base;
      end
      pending = expected_words.size();
   end

endmodule

[tb/four_level_page_walker_tb.sv]
// Top of the page walker testbench: clock, reset, stimulus phases and the verdict.
// Depends on fpw_pkg, four_level_page_walker and fpw_checker.
`timescale 1ns / 1ps

module four_level_page_walker_tb;
   import fpw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_we         = 1'b0;
   logic [ADDR_W-1:0]  csr_table_base = '0;
   logic               push           = 1'b0;
   logic               req_type       = REQ_TRANSLATE;
   logic [VA_W-1:0]    req_virt_addr  = '0;
   logic [ENTRY_W-1:0] req_read_data  = '0;
   logic               pop            = 1'b0;
   logic               full;
   logic               empty;
   logic               rsp_out_kind;
   logic [ADDR_W-1:0]  rsp_address;

   int   fail_count;
   int   pending;
   logic walk_open;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   int   words_sent    = 0;

   four_level_page_walker dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_table_base (csr_table_base),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_virt_addr  (req_virt_addr),
      .req_read_data  (req_read_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_address    (rsp_address)
   );

   fpw_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_table_base (csr_table_base),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_virt_addr  (req_virt_addr),
      .req_read_data  (req_read_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_address    (rsp_address),
      .fail_count     (fail_count),
      .pending        (pending),
      .walk_open      (walk_open)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls on pop
   always @(negedge clock)
      pop <= !reset && ($urandom_range(0, 99) >= stall_pct);

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("four_level_page_walker_tb failed");
      $finish;
   end

   // Random field values, with the all-zero and all-one corners now and then
   function automatic logic [VA_W-1:0] random_vaddr();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return VA_W'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [ENTRY_W-1:0] random_entry();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one input word, with random idle cycles first; starts and ends at a falling edge
   task automatic send_word(input logic kind, input logic [VA_W-1:0] va,
                            input logic [ENTRY_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_type      <= kind;
      req_virt_addr <= va;
      req_read_data <= data;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // Close any open walk, drain all results and let the pipeline empty
   task automatic settle();
      while (walk_open) send_word(REQ_REPLY, random_vaddr(), random_entry());
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_table_base(input logic [ADDR_W-1:0] value);
      csr_we         <= 1'b1;
      csr_table_base <= value;
      @(negedge clock);
      csr_we         <= 1'b0;
   endtask

   // Corner cases: stray reply, zero and all-one walks, dropped translate, bit patterns
   task automatic directed_words();
      // reply with no walk open is dropped; read_data ignored on translate
      send_word(REQ_REPLY, '1, '1);
      send_word(REQ_TRANSLATE, '0, '1);
      repeat (4) send_word(REQ_REPLY, '0, '0);
      // flags and high entry bits ignored, frame and index at all ones,
      // translate inside an open walk is dropped
      send_word(REQ_TRANSLATE, '1, '0);
      send_word(REQ_REPLY, '1, '1);
      send_word(REQ_TRANSLATE, 48'h1234_5678_9ABC, '1);
      repeat (3) send_word(REQ_REPLY, '1, '1);
      send_word(REQ_TRANSLATE, 48'hAAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      repeat (4) send_word(REQ_REPLY, 48'h5555_5555_5555, 64'h5555_5555_5555_5555);
      send_word(REQ_TRANSLATE, 48'h5555_5555_5555, '0);
      repeat (4) send_word(REQ_REPLY, '0, 64'hAAAA_AAAA_AAAA_AAAA);
   endtask

   // Mostly full walks, some with a dropped translate inside; the rest stray
   // replies and walks cut short that later replies finish
   task automatic random_words(input int quota);
      int stop_at;
      int roll;
      int replies;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            send_word(REQ_TRANSLATE, random_vaddr(), random_entry());
            repeat (4) begin
               if ($urandom_range(0, 99) < 8)
                  send_word(REQ_TRANSLATE, random_vaddr(), random_entry());
               send_word(REQ_REPLY, random_vaddr(), random_entry());
            end
         end else if (roll < 88) begin
            send_word(REQ_REPLY, random_vaddr(), random_entry());
         end else begin
            replies = $urandom_range(0, 3);
            send_word(REQ_TRANSLATE, random_vaddr(), random_entry());
            repeat (replies) send_word(REQ_REPLY, random_vaddr(), random_entry());
         end
      end
   endtask

   task automatic start_phase(input logic [ADDR_W-1:0] base, input int idle_pct,
                              input int stall);
      settle();
      write_table_base(base);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
   endtask

   // Stimulus and verdict
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // low base bits set, so they must be ignored
      start_phase(52'h1_2345_6789_AFFF, 0, 0);
      directed_words();
      random_words(70);

      start_phase('1, 61, 0);
      random_words(95);

      start_phase('0, 0, 61);
      random_words(95);

      start_phase(ADDR_W'({$urandom, $urandom}), 15, 15);
      random_words(95);

      start_phase(ADDR_W'({$urandom, $urandom}), 0, 0);
      random_words(95);

      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (fail_count == 0 && pending == 0)
         $display("four_level_page_walker_tb passed");
      else
         $display("four_level_page_walker_tb failed");
      $finish;
   end

endmodule
